[hw/rtl/imhq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

  // Fixed field widths of the request and result ports.
  localparam int unsigned VID_W    = 10;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 11;
  // Vertex ids span the whole id field.
  localparam int unsigned NUM_IDS  = 1 << VID_W;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

  // Controller states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_POP1,
    S_POP2,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP
  } ctl_state_e;

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_REJECT,
    OP_INS_SETUP,
    OP_UPD_READ,
    OP_UPD_LOAD,
    OP_POP_READ_TOP,
    OP_POP_ONLY,
    OP_POP_TAKE,
    OP_POP_LOAD,
    OP_UP_READ,
    OP_UP_SWAP,
    OP_DN_READ_L,
    OP_DN_READ_R,
    OP_DN_SWAP
  } dp_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic reject;
    logic is_insert;
    logic is_update;
    logic upd_up;
    logic pop_last;
    logic at_root;
    logic up_swap;
    logic dn_leaf;
    logic dn_swap;
  } dp_flags_t;

endpackage

[hw/rtl/imhq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_ctrl
// Sequencer of the heap queue: clears the position store after reset, then
// steps each request through lookup, sift-up or sift-down.
// ----------------------------------------------------------------------------
module imhq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  imhq_pkg::dp_flags_t flags_i,
  output imhq_pkg::dp_op_e    op_o,
  output logic                place_o
);
  import imhq_pkg::*;

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (flags_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_LOOK;
      end
      S_LOOK: begin
        if (flags_i.reject)         state_d = S_IDLE;
        else if (flags_i.is_insert) state_d = S_UP_RD;
        else if (flags_i.is_update) state_d = S_UPD;
        else                        state_d = S_POP1;
      end
      S_UPD: begin
        state_d = flags_i.upd_up ? S_UP_RD : S_DN_RD;
      end
      S_POP1: begin
        state_d = flags_i.pop_last ? S_IDLE : S_POP2;
      end
      S_POP2:   state_d = S_DN_RD;
      S_UP_RD: begin
        state_d = flags_i.at_root ? S_IDLE : S_UP_CMP;
      end
      S_UP_CMP: begin
        state_d = flags_i.up_swap ? S_UP_RD : S_IDLE;
      end
      S_DN_RD: begin
        state_d = flags_i.dn_leaf ? S_IDLE : S_DN_RDR;
      end
      S_DN_RDR: state_d = S_DN_CMP;
      S_DN_CMP: begin
        state_d = flags_i.dn_swap ? S_DN_RD : S_IDLE;
      end
      default:  state_d = S_CLEAR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    op_o    = OP_NONE;
    place_o = 1'b0;
    case (state_q)
      S_CLEAR: op_o = OP_CLEAR;
      S_IDLE: begin
        if (start) op_o = OP_ACCEPT;
      end
      S_LOOK: begin
        if (flags_i.reject)         op_o = OP_REJECT;
        else if (flags_i.is_insert) op_o = OP_INS_SETUP;
        else if (flags_i.is_update) op_o = OP_UPD_READ;
        else                        op_o = OP_POP_READ_TOP;
      end
      S_UPD:  op_o = OP_UPD_LOAD;
      S_POP1: op_o = flags_i.pop_last ? OP_POP_ONLY : OP_POP_TAKE;
      S_POP2: op_o = OP_POP_LOAD;
      S_UP_RD: begin
        if (flags_i.at_root) place_o = 1'b1;
        else                 op_o    = OP_UP_READ;
      end
      S_UP_CMP: begin
        if (flags_i.up_swap) op_o    = OP_UP_SWAP;
        else                 place_o = 1'b1;
      end
      S_DN_RD: begin
        if (flags_i.dn_leaf) place_o = 1'b1;
        else                 op_o    = OP_DN_READ_L;
      end
      S_DN_RDR: op_o = OP_DN_READ_R;
      S_DN_CMP: begin
        if (flags_i.dn_swap) op_o    = OP_DN_SWAP;
        else                 place_o = 1'b1;
      end
      default: op_o = OP_NONE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

[hw/rtl/imhq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhq_datapath
// Heap store (vertex and key per slot), vertex position store, entry count,
// the held entry of a sift and the result registers.
// ----------------------------------------------------------------------------
module imhq_datapath #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  imhq_pkg::dp_op_e                op_i,
  input  logic                            place_i,
  output imhq_pkg::dp_flags_t             flags_o,
  input  logic [imhq_pkg::KIND_W-1:0]     kind_i,
  input  logic [imhq_pkg::VID_W-1:0]      vertex_id_i,
  input  logic [imhq_pkg::KEY_W-1:0]      key_i,
  output logic                            result_valid_o,
  output logic [imhq_pkg::VID_W-1:0]      popped_vertex_o,
  output logic [imhq_pkg::KEY_W-1:0]      popped_key_o,
  output logic [imhq_pkg::STATUS_W-1:0]   status_o,
  output logic [imhq_pkg::OCC_W-1:0]      occupancy_o
);
  import imhq_pkg::*;

  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned PW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = VID_W + KW;
  localparam logic [PW-1:0] ABSENT = PW'(MAX_VERTICES);

  // Stores: heap entries hold {vertex, key}; positions are indexed by vertex.
  logic [EW-1:0] heap_mem [MAX_VERTICES];
  logic [PW-1:0] pos_mem  [NUM_IDS];

  logic [EW-1:0]       heap_rd_q;
  logic [PW-1:0]       pos_rd_q;
  logic                heap_re, heap_we, pos_re, pos_we;
  logic [SW-1:0]       heap_raddr, heap_waddr;
  logic [EW-1:0]       heap_wdata;
  logic [VID_W-1:0]    pos_raddr, pos_waddr;
  logic [PW-1:0]       pos_wdata;

  // Control and payload registers.
  logic [PW-1:0]       cnt_q, cnt_d;
  logic [VID_W-1:0]    clr_q;
  logic                res_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [VID_W-1:0]    vid_q;
  logic [KW-1:0]       key_q;
  logic [PW-1:0]       pos_q, pos_d;
  logic [EW-1:0]       cur_q, cur_d;
  logic [EW-1:0]       ch_q;
  logic [VID_W-1:0]    pv_q, pv_d;
  logic [KW-1:0]       pk_q, pk_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic                finish;

  // Derived values.
  logic [PW:0]         left, right, cnt_x;
  logic [PW-1:0]       parent;
  logic                vid_ok, present, full, has_right, take_right;
  logic [EW-1:0]       pick;
  logic [PW-1:0]       pick_idx;
  logic [STATUS_W-1:0] err_code;

  assign cnt_x     = {1'b0, cnt_q};
  assign left      = {pos_q, 1'b1};
  assign right     = left + 1'b1;
  assign parent    = (pos_q - 1'b1) >> 1;
  assign vid_ok    = (32'(vid_q) < MAX_VERTICES);
  assign present   = (pos_rd_q != ABSENT);
  assign full      = (cnt_q == ABSENT);
  assign has_right = (right < cnt_x);
  // Right child wins on equal keys.
  assign take_right = has_right && (ch_q[KW-1:0] >= heap_rd_q[KW-1:0]);
  assign pick       = take_right ? heap_rd_q : ch_q;
  assign pick_idx   = take_right ? right[PW-1:0] : left[PW-1:0];

  // Error code of the lookup step.
  always_comb begin
    err_code = ST_OK;
    case (kind_q)
      KIND_INSERT: begin
        if (!vid_ok)      err_code = ST_FULL;
        else if (present) err_code = ST_DUP;
        else if (full)    err_code = ST_FULL;
      end
      KIND_UPDATE: begin
        if (!vid_ok || !present) err_code = ST_ABSENT;
      end
      KIND_POP: begin
        if (cnt_q == '0) err_code = ST_EMPTY;
      end
      default: err_code = ST_OK;
    endcase
  end

  // Status flags for the controller.
  always_comb begin
    flags_o.clear_done = (clr_q == VID_W'(NUM_IDS - 1));
    flags_o.reject     = (err_code != ST_OK) || (kind_q != KIND_INSERT &&
                         kind_q != KIND_UPDATE && kind_q != KIND_POP);
    flags_o.is_insert  = (kind_q == KIND_INSERT);
    flags_o.is_update  = (kind_q == KIND_UPDATE);
    flags_o.upd_up     = (key_q < heap_rd_q[KW-1:0]);
    flags_o.pop_last   = (cnt_q == PW'(1));
    flags_o.at_root    = (pos_q == '0);
    flags_o.up_swap    = (cur_q[KW-1:0] < heap_rd_q[KW-1:0]);
    flags_o.dn_leaf    = (left >= cnt_x);
    flags_o.dn_swap    = (pick[KW-1:0] < cur_q[KW-1:0]);
  end

  // Memory port control and register updates for each command.
  always_comb begin
    heap_re    = 1'b0;
    heap_we    = 1'b0;
    pos_re     = 1'b0;
    pos_we     = 1'b0;
    heap_raddr = '0;
    heap_waddr = pos_q[SW-1:0];
    heap_wdata = cur_q;
    pos_raddr  = vertex_id_i;
    pos_waddr  = cur_q[EW-1:KW];
    pos_wdata  = pos_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    pv_d       = pv_q;
    pk_d       = pk_q;
    st_d       = st_q;
    finish     = 1'b0;
    case (op_i)
      OP_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = ABSENT;
      end
      OP_ACCEPT: begin
        pos_re = 1'b1;
        pv_d   = '0;
        pk_d   = '0;
        st_d   = ST_OK;
      end
      OP_REJECT: begin
        st_d   = err_code;
        finish = 1'b1;
      end
      OP_INS_SETUP: begin
        cur_d = {vid_q, key_q};
        pos_d = cnt_q;
        cnt_d = cnt_q + 1'b1;
      end
      OP_UPD_READ: begin
        heap_re    = 1'b1;
        heap_raddr = pos_rd_q[SW-1:0];
        pos_d      = pos_rd_q;
      end
      OP_UPD_LOAD: cur_d = {vid_q, key_q};
      OP_POP_READ_TOP: begin
        heap_re    = 1'b1;
        heap_raddr = '0;
      end
      OP_POP_ONLY, OP_POP_TAKE: begin
        pos_we     = 1'b1;
        pos_waddr  = heap_rd_q[EW-1:KW];
        pos_wdata  = ABSENT;
        cnt_d      = cnt_q - 1'b1;
        pv_d       = heap_rd_q[EW-1:KW];
        pk_d       = heap_rd_q[KW-1:0];
        heap_re    = (op_i == OP_POP_TAKE);
        heap_raddr = cnt_d[SW-1:0];
        finish     = (op_i == OP_POP_ONLY);
      end
      OP_POP_LOAD: begin
        cur_d = heap_rd_q;
        pos_d = '0;
      end
      OP_UP_READ: begin
        heap_re    = 1'b1;
        heap_raddr = parent[SW-1:0];
      end
      OP_UP_SWAP: begin
        heap_we   = 1'b1;
        heap_wdata = heap_rd_q;
        pos_we    = 1'b1;
        pos_waddr = heap_rd_q[EW-1:KW];
        pos_d     = parent;
      end
      OP_DN_READ_L: begin
        heap_re    = 1'b1;
        heap_raddr = left[SW-1:0];
      end
      OP_DN_READ_R: begin
        heap_re    = has_right;
        heap_raddr = right[SW-1:0];
      end
      OP_DN_SWAP: begin
        heap_we    = 1'b1;
        heap_wdata = pick;
        pos_we     = 1'b1;
        pos_waddr  = pick[EW-1:KW];
        pos_d      = pick_idx;
      end
      default: begin
        heap_re = 1'b0;
      end
    endcase
    // Drop the held entry into its final slot and end the request.
    if (place_i) begin
      heap_we = 1'b1;
      pos_we  = 1'b1;
      finish  = 1'b1;
    end
  end

  // Heap store.
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (heap_re) heap_rd_q <= heap_mem[heap_raddr];
  end

  // Position store.
  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    if (pos_re) pos_rd_q <= pos_mem[pos_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      res_valid_q <= finish;
      if (op_i == OP_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_ACCEPT) begin
      kind_q <= kind_i;
      vid_q  <= vertex_id_i;
      key_q  <= key_i[KW-1:0];
    end
    pos_q <= pos_d;
    cur_q <= cur_d;
    pv_q  <= pv_d;
    pk_q  <= pk_d;
    st_q  <= st_d;
    if (op_i == OP_DN_READ_R) ch_q <= heap_rd_q;
  end

  assign result_valid_o  = res_valid_q;
  assign popped_vertex_o = pv_q;
  assign popped_key_o    = KEY_W'(pk_q);
  assign status_o        = st_q;
  assign occupancy_o     = OCC_W'(cnt_q);

`ifndef SYNTH
  // The entry count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ABSENT) else $error("entry count above capacity");

  // A result strobe is never held high.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q) else $error("result strobe held");

  // A failed request returns no popped vertex or key.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && st_q != ST_OK) |-> (pv_q == '0 && pk_q == '0))
    else $error("failed request carries popped data");

  // The count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1 ||
                                 cnt_q == $past(cnt_q) - 1'b1))
    else $error("entry count jumped");
`endif

endmodule

[hw/rtl/indexed_min_heap_queue.sv]
`timescale 1ns / 1ps
// Each request runs a lookup step, then one sift level after another, up or down.
// Requests are handled one at a time.
// The heap store sets the pace: one read or write per cycle, never both.
// After reset, busy stays high while the position store clears.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// indexed_min_heap_queue
// Indexed binary min-heap with insert, key update and pop-minimum requests.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned KEY_BITS     = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [imhq_pkg::KIND_W-1:0]   kind_i,
  input  logic [imhq_pkg::VID_W-1:0]    vertex_id_i,
  input  logic [imhq_pkg::KEY_W-1:0]    key_i,
  output logic                          result_valid_o,
  output logic [imhq_pkg::VID_W-1:0]    popped_vertex_o,
  output logic [imhq_pkg::KEY_W-1:0]    popped_key_o,
  output logic [imhq_pkg::STATUS_W-1:0] status_o,
  output logic [imhq_pkg::OCC_W-1:0]    occupancy_o
);
  import imhq_pkg::*;

  dp_flags_t flags;
  dp_op_e    op;
  logic      place;

  // Request sequencer.
  imhq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .flags_i (flags),
    .op_o    (op),
    .place_o (place)
  );

  // Stores and arithmetic.
  imhq_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .KEY_BITS     (KEY_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .place_i         (place),
    .flags_o         (flags),
    .kind_i          (kind_i),
    .vertex_id_i     (vertex_id_i),
    .key_i           (key_i),
    .result_valid_o  (result_valid_o),
    .popped_vertex_o (popped_vertex_o),
    .popped_key_o    (popped_key_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

endmodule
